@@ sv/mfva_pkg.sv @@
// ----------------------------------------------------------------------------
// mfva_pkg
// Shared widths, types and state codes of the mesh feature volume accumulator.
// ----------------------------------------------------------------------------
package mfva_pkg;

  localparam int MAX_FEATURES = 1024;
  localparam int COORD_WIDTH  = 16;

  localparam int FIELD_W   = 16;
  localparam int LABEL_W   = 11;
  localparam int OUT_IDX_W = 10;
  localparam int SUM_W     = 64;
  localparam int IDX_W     = $clog2(MAX_FEATURES);

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int MINOR_W = PROD_W + 1;
  localparam int TERM_W  = DIFF_W + MINOR_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [MINOR_W-1:0]     minor_t;
  typedef logic signed [TERM_W-1:0]      term_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [IDX_W-1:0]              idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } state_e;

endpackage

@@ sv/mfva_ram.sv @@
// ----------------------------------------------------------------------------
// mfva_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mfva_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mfva_det.sv @@
// ----------------------------------------------------------------------------
// mfva_det
// Pipelined 3x3 determinant of (b-a, c-a, -a): six times the signed volume.
// ----------------------------------------------------------------------------
module mfva_det
  import mfva_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  vec_t vtx_a_i,
  input  vec_t vtx_b_i,
  input  vec_t vtx_c_i,
  output logic done_o,
  output sum_t det_o
);

  logic [4:0] vld_q;
  diff_t      ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
  prod_t      p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  minor_t     m0_q, m1_q, m2_q;
  term_t      t0_q, t1_q, t2_q;
  sum_t       det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax_q <= diff_t'(vtx_b_i.x) - diff_t'(vtx_a_i.x);
      ay_q <= diff_t'(vtx_b_i.y) - diff_t'(vtx_a_i.y);
      az_q <= diff_t'(vtx_b_i.z) - diff_t'(vtx_a_i.z);
      bx_q <= diff_t'(vtx_c_i.x) - diff_t'(vtx_a_i.x);
      by_q <= diff_t'(vtx_c_i.y) - diff_t'(vtx_a_i.y);
      bz_q <= diff_t'(vtx_c_i.z) - diff_t'(vtx_a_i.z);
      cx_q <= -diff_t'(vtx_a_i.x);
      cy_q <= -diff_t'(vtx_a_i.y);
      cz_q <= -diff_t'(vtx_a_i.z);
    end
    // 2x2 minor products
    if (vld_q[0]) begin
      p0_q <= prod_t'(by_q) * prod_t'(cz_q);
      p1_q <= prod_t'(cy_q) * prod_t'(bz_q);
      p2_q <= prod_t'(ay_q) * prod_t'(cz_q);
      p3_q <= prod_t'(cy_q) * prod_t'(az_q);
      p4_q <= prod_t'(ay_q) * prod_t'(bz_q);
      p5_q <= prod_t'(by_q) * prod_t'(az_q);
    end
    if (vld_q[1]) begin
      m0_q <= minor_t'(p0_q) - minor_t'(p1_q);
      m1_q <= minor_t'(p2_q) - minor_t'(p3_q);
      m2_q <= minor_t'(p4_q) - minor_t'(p5_q);
    end
    // cofactor expansion along the x row
    if (vld_q[2]) begin
      t0_q <= term_t'(ax_q) * term_t'(m0_q);
      t1_q <= term_t'(bx_q) * term_t'(m1_q);
      t2_q <= term_t'(cx_q) * term_t'(m2_q);
    end
    if (vld_q[3]) begin
      det_q <= sum_t'(t0_q) - sum_t'(t1_q) + sum_t'(t2_q);
    end
  end

  assign done_o = vld_q[4];
  assign det_o  = det_q;

endmodule

@@ sv/mesh_feature_volume_accumulator.sv @@
// ----------------------------------------------------------------------------
// mesh_feature_volume_accumulator
// Per-feature running sums of six times the signed volume of mesh triangles.
// ----------------------------------------------------------------------------
// One triangle per input beat. After reset the sum table is swept to zero,
// one entry a cycle; input is stalled meanwhile. A triangle then passes the
// determinant pipeline (differences, products, minors, terms, sum), whose
// result issues the table read, then one read-modify-write per valid label
// (none, one or two) on the single write port of the sum table, and returns
// to idle before the next triangle is accepted. A stalled output holds the
// update until it frees. The front label's result comes first, the back
// label's second, and the final result of a triangle has last_of_item_o set.
// Labels of -1 or out of range update nothing.
// ----------------------------------------------------------------------------
module mesh_feature_volume_accumulator
  import mfva_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [FIELD_W-1:0]  vertex_a_x_i,
  input  logic signed [FIELD_W-1:0]  vertex_a_y_i,
  input  logic signed [FIELD_W-1:0]  vertex_a_z_i,
  input  logic signed [FIELD_W-1:0]  vertex_b_x_i,
  input  logic signed [FIELD_W-1:0]  vertex_b_y_i,
  input  logic signed [FIELD_W-1:0]  vertex_b_z_i,
  input  logic signed [FIELD_W-1:0]  vertex_c_x_i,
  input  logic signed [FIELD_W-1:0]  vertex_c_y_i,
  input  logic signed [FIELD_W-1:0]  vertex_c_z_i,
  input  logic signed [LABEL_W-1:0]  label_front_i,
  input  logic signed [LABEL_W-1:0]  label_back_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [OUT_IDX_W-1:0]       feature_index_o,
  output logic signed [SUM_W-1:0]    volume_times_six_o,
  output logic                       last_of_item_o
);

  state_e state_q, state_d;
  idx_t   clr_addr_q, clr_addr_d;
  idx_t   front_idx_q, back_idx_q;
  logic   front_ok_q, back_ok_q;
  logic   phase_q, phase_d;
  logic   fwd_q, fwd_d;
  sum_t   sum_prev_q;

  logic   out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0] out_idx_q;
  sum_t   out_sum_q;
  logic   out_last_q;

  logic   in_fire, front_ok, back_ok;
  vec_t   vtx_a, vtx_b, vtx_c;
  logic   det_done;
  sum_t   det;

  logic   ram_we, ram_re;
  idx_t   ram_waddr, ram_raddr;
  sum_t   ram_wdata, ram_rdata;

  logic   out_free, upd_fire;
  idx_t   upd_idx;
  sum_t   upd_base, upd_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign front_ok = !label_front_i[LABEL_W-1] &&
                    (32'(label_front_i[LABEL_W-2:0]) < MAX_FEATURES);
  assign back_ok  = !label_back_i[LABEL_W-1] &&
                    (32'(label_back_i[LABEL_W-2:0]) < MAX_FEATURES);

  assign vtx_a = '{x: vertex_a_x_i[COORD_WIDTH-1:0], y: vertex_a_y_i[COORD_WIDTH-1:0],
                   z: vertex_a_z_i[COORD_WIDTH-1:0]};
  assign vtx_b = '{x: vertex_b_x_i[COORD_WIDTH-1:0], y: vertex_b_y_i[COORD_WIDTH-1:0],
                   z: vertex_b_z_i[COORD_WIDTH-1:0]};
  assign vtx_c = '{x: vertex_c_x_i[COORD_WIDTH-1:0], y: vertex_c_y_i[COORD_WIDTH-1:0],
                   z: vertex_c_z_i[COORD_WIDTH-1:0]};

  mfva_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .vtx_a_i (vtx_a),
    .vtx_b_i (vtx_b),
    .vtx_c_i (vtx_c),
    .done_o  (det_done),
    .det_o   (det)
  );

  mfva_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_FEATURES)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read-modify-write; a back update on the same entry takes the front sum
  assign out_free = !out_valid_q || !out_stall_i;
  assign upd_fire = (state_q == ST_WRITE) && out_free;
  assign upd_idx  = phase_q ? back_idx_q : front_idx_q;
  assign upd_base = (phase_q && fwd_q) ? sum_prev_q : ram_rdata;
  assign upd_sum  = phase_q ? (upd_base - det) : (upd_base + det);

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    phase_d     = phase_q;
    fwd_d       = fwd_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = upd_idx;
    ram_wdata   = upd_sum;
    ram_re      = 1'b0;
    ram_raddr   = front_idx_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + idx_t'(1);
        if (clr_addr_q == idx_t'(MAX_FEATURES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (det_done) begin
          fwd_d = 1'b0;
          if (front_ok_q) begin
            ram_re  = 1'b1;
            phase_d = 1'b0;
            state_d = ST_WRITE;
          end else if (back_ok_q) begin
            ram_re    = 1'b1;
            ram_raddr = back_idx_q;
            phase_d   = 1'b1;
            state_d   = ST_WRITE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        if (upd_fire) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          if (!phase_q && back_ok_q) begin
            ram_re    = 1'b1;
            ram_raddr = back_idx_q;
            phase_d   = 1'b1;
            fwd_d     = (front_idx_q == back_idx_q);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      phase_q     <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      phase_q     <= phase_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      front_ok_q  <= front_ok;
      back_ok_q   <= back_ok;
      front_idx_q <= label_front_i[IDX_W-1:0];
      back_idx_q  <= label_back_i[IDX_W-1:0];
    end
    if (upd_fire) begin
      sum_prev_q <= upd_sum;
      out_idx_q  <= OUT_IDX_W'(upd_idx);
      out_sum_q  <= upd_sum;
      out_last_q <= phase_q || !back_ok_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign feature_index_o    = out_idx_q;
  assign volume_times_six_o = out_sum_q;
  assign last_of_item_o     = out_last_q;

endmodule

@@ sv/mfva_checker.sv @@
// ----------------------------------------------------------------------------
// mfva_checker
// Port-level checks of the mesh feature volume accumulator, bound to the top.
// ----------------------------------------------------------------------------
module mfva_checker
  import mfva_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [OUT_IDX_W-1:0]      feature_index_o,
  input logic signed [SUM_W-1:0]   volume_times_six_o,
  input logic                      last_of_item_o
);

  logic in_beat, out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(feature_index_o) &&
      $stable(volume_times_six_o) && $stable(last_of_item_o))
    else $error("stalled result beat changed");

  // the determinant pipeline keeps the input closed for a while
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input reopened before the item was done");

  // a non-final beat is always followed by its partner
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !last_of_item_o |=> out_valid_o)
    else $error("missing second result of a triangle");

  // no result while the input is open and nothing is pending
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result without an accepted triangle");

endmodule

bind mesh_feature_volume_accumulator mfva_checker u_mfva_checker (.*);
